// ----- sv/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// Shell script tokenizer package
// Shared types, token codes, error codes and character constants.
// ----------------------------------------------------------------------------
package sst_pkg;

    // Size of the token text buffer; a kept text holds at most TEXT_BYTES-1 bytes.
    localparam int TEXT_BYTES = 16;
    localparam int TC_W       = $clog2(TEXT_BYTES) + 1;
    localparam logic [TC_W-1:0] TEXT_KEEP = TC_W'(TEXT_BYTES - 1);

    // Depth of the result bundle queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);

    localparam logic [15:0] LIMIT_RESET = 16'd256;

    // Result kinds.
    localparam logic [1:0] RK_TEXT   = 2'd0;
    localparam logic [1:0] RK_RECORD = 2'd1;
    localparam logic [1:0] RK_ERROR  = 2'd2;

    // Token types.
    localparam logic [4:0] TK_NEWLINE = 5'd0;
    localparam logic [4:0] TK_STRING  = 5'd1;
    localparam logic [4:0] TK_NUMBER  = 5'd2;
    localparam logic [4:0] TK_VAR     = 5'd3;
    localparam logic [4:0] TK_IDENT   = 5'd4;
    localparam logic [4:0] TK_TRUE    = 5'd5;
    localparam logic [4:0] TK_FALSE   = 5'd6;
    localparam logic [4:0] TK_RANGE   = 5'd7;
    localparam logic [4:0] TK_EQ      = 5'd8;
    localparam logic [4:0] TK_NEQ     = 5'd9;
    localparam logic [4:0] TK_GTE     = 5'd10;
    localparam logic [4:0] TK_LTE     = 5'd11;
    localparam logic [4:0] TK_AT      = 5'd12;
    localparam logic [4:0] TK_PIPE    = 5'd13;
    localparam logic [4:0] TK_QUEST   = 5'd14;
    localparam logic [4:0] TK_PERCENT = 5'd15;
    localparam logic [4:0] TK_LBRACK  = 5'd16;
    localparam logic [4:0] TK_RBRACK  = 5'd17;
    localparam logic [4:0] TK_LPAREN  = 5'd18;
    localparam logic [4:0] TK_RPAREN  = 5'd19;
    localparam logic [4:0] TK_DOT     = 5'd20;
    localparam logic [4:0] TK_COMMA   = 5'd21;
    localparam logic [4:0] TK_SEMI    = 5'd22;
    localparam logic [4:0] TK_ASSIGN  = 5'd23;
    localparam logic [4:0] TK_GT      = 5'd24;
    localparam logic [4:0] TK_LT      = 5'd25;
    localparam logic [4:0] TK_EOF     = 5'd26;

    // Error codes.
    localparam logic [2:0] ER_CHAR     = 3'd0;
    localparam logic [2:0] ER_EMPTYVAR = 3'd1;
    localparam logic [2:0] ER_LONG     = 3'd2;
    localparam logic [2:0] ER_UNTERM   = 3'd3;
    localparam logic [2:0] ER_MANY     = 3'd4;

    // Characters.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Scanner modes.
    typedef enum logic [3:0] {
        M_IDLE, M_NUMBER, M_IDENT, M_VAR_START, M_VAR,
        M_STRING, M_STRING_ESC, M_HOLD, M_AFTER_CR, M_ERROR
    } t_mode;

    // One result item without its run flag.
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  ttype;
        logic [7:0]  text;
        logic [15:0] offset;
        logic [15:0] line;
        logic [15:0] column;
        logic [3:0]  tlen;
        logic [15:0] num;
        logic [2:0]  ecode;
    } t_result;

    // All results caused by one input item.
    typedef struct packed {
        t_result [2:0] res;
        logic [1:0]    cnt;
    } t_bundle;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic valid;
    } t_qstat;

    function automatic logic f_is_word(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
               (b >= "0" && b <= "9") || b == "_";
    endfunction

    function automatic logic [7:0] f_fold(input logic [7:0] b);
        return (b >= "a" && b <= "z") ? b - 8'd32 : b;
    endfunction

    // Keeps the TRUE and FALSE candidates alive while the folded byte matches.
    function automatic logic [1:0] f_kw(input logic [1:0] km, input logic [TC_W-1:0] pos,
                                        input logic [7:0] f);
        logic [1:0] k;
        logic [7:0] ct;
        logic [7:0] cf;
        k = km;
        case (pos)
            TC_W'(0): begin ct = "T"; cf = "F"; end
            TC_W'(1): begin ct = "R"; cf = "A"; end
            TC_W'(2): begin ct = "U"; cf = "L"; end
            TC_W'(3): begin ct = "E"; cf = "S"; end
            TC_W'(4): begin ct = 8'h00; cf = "E"; end
            default: begin ct = 8'h00; cf = 8'h00; end
        endcase
        if (pos >= TC_W'(4) || ct != f) k[0] = 1'b0;
        if (pos >= TC_W'(5) || cf != f) k[1] = 1'b0;
        return k;
    endfunction

    // Single-byte punctuation; bit 5 flags a match.
    function automatic logic [5:0] f_single(input logic [7:0] b);
        case (b)
            "@": return {1'b1, TK_AT};
            "|": return {1'b1, TK_PIPE};
            "?": return {1'b1, TK_QUEST};
            "%": return {1'b1, TK_PERCENT};
            "[": return {1'b1, TK_LBRACK};
            "]": return {1'b1, TK_RBRACK};
            "(": return {1'b1, TK_LPAREN};
            ")": return {1'b1, TK_RPAREN};
            ",": return {1'b1, TK_COMMA};
            ";": return {1'b1, TK_SEMI};
            default: return 6'd0;
        endcase
    endfunction

    function automatic t_result f_text(input logic [7:0] b);
        t_result r;
        r      = '0;
        r.kind = RK_TEXT;
        r.text = b;
        return r;
    endfunction

    function automatic t_result f_err(input logic [2:0] code, input logic [15:0] off,
                                      input logic [15:0] ln, input logic [15:0] col);
        t_result r;
        r        = '0;
        r.kind   = RK_ERROR;
        r.offset = off;
        r.line   = ln;
        r.column = col;
        r.ecode  = code;
        return r;
    endfunction

    function automatic t_result f_rec(input logic [4:0] ty, input logic [15:0] off,
                                      input logic [15:0] ln, input logic [15:0] col,
                                      input logic [3:0] len, input logic [15:0] num);
        t_result r;
        r        = '0;
        r.kind   = RK_RECORD;
        r.ttype  = ty;
        r.offset = off;
        r.line   = ln;
        r.column = col;
        r.tlen   = len;
        r.num    = num;
        return r;
    endfunction

endpackage

// ----- sv/sst_in_if.sv -----
// ----------------------------------------------------------------------------
// Source byte channel
// Valid/ready channel carrying one source byte or the end marker.
// ----------------------------------------------------------------------------
interface sst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_source;

    modport source(output valid, char_byte, end_of_source, input ready);
    modport sink(input valid, char_byte, end_of_source, output ready);
endinterface

// ----- sv/sst_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying text bytes, token records and error records.
// ----------------------------------------------------------------------------
interface sst_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [4:0]  token_type;
    logic [7:0]  text_byte;
    logic [15:0] offset;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [3:0]  text_length;
    logic [15:0] number_value;
    logic [2:0]  error_code;
    logic        last_in_run;

    modport source(output valid, result_kind, token_type, text_byte, offset, line_number,
                   column_number, text_length, number_value, error_code, last_in_run,
                   input ready);
    modport sink(input valid, result_kind, token_type, text_byte, offset, line_number,
                 column_number, text_length, number_value, error_code, last_in_run,
                 output ready);
endinterface

// ----- sv/sst_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the token limit register.
// ----------------------------------------------------------------------------
interface sst_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] token_limit;

    modport source(output valid, token_limit, input ready);
    modport sink(input valid, token_limit, output ready);
endinterface

// ----- sv/sst_front.sv -----
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts source bytes, runs the scanner and pushes a bundle of results.
// ----------------------------------------------------------------------------
module sst_front
    import sst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sst_in_if.sink      i_in,
    sst_cfg_if.sink     i_cfg,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_bundle     o_bundle
);

    t_mode            r_mode, n_mode;
    logic [15:0]      r_off, n_off;
    logic [15:0]      r_ln, n_ln;
    logic [15:0]      r_col, n_col;
    logic [15:0]      r_so, n_so;
    logic [15:0]      r_sl, n_sl;
    logic [15:0]      r_sc, n_sc;
    logic [15:0]      r_acc, n_acc;
    logic [TC_W-1:0]  r_tc, n_tc;
    logic [15:0]      r_tok, n_tok;
    logic [1:0]       r_km, n_km;
    logic [7:0]       r_held, n_held;
    logic [15:0]      r_limit;

    logic             accept;
    t_bundle          bnd;

    assign i_in.ready  = !i_qstat.full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_in.ready;
    assign o_push      = accept && (bnd.cnt != 2'd0);
    assign o_bundle    = bnd;

    // Scanner: one source byte in, up to two results out.
    always_comb begin
        logic [7:0]  b;
        logic [7:0]  f;
        logic [1:0]  nr;
        logic        aq;
        logic        adisp;
        logic        disp;
        logic [4:0]  aty;
        logic [15:0] anum;
        logic [5:0]  sg;
        logic [4:0]  pty;
        logic        pok;

        b      = i_in.char_byte;
        f      = f_fold(b);
        nr     = 2'd0;
        aq     = 1'b0;
        adisp  = 1'b0;
        disp   = 1'b0;
        aty    = TK_IDENT;
        anum   = 16'd0;
        sg     = f_single(b);
        pty    = TK_RANGE;
        pok    = 1'b0;
        bnd    = '0;
        n_mode = r_mode;
        n_off  = r_off;
        n_ln   = r_ln;
        n_col  = r_col;
        n_so   = r_so;
        n_sl   = r_sl;
        n_sc   = r_sc;
        n_acc  = r_acc;
        n_tc   = r_tc;
        n_tok  = r_tok;
        n_km   = r_km;
        n_held = r_held;

        if (r_mode == M_ERROR) begin
            // Sticky error: only the end marker has an effect.
            if (i_in.end_of_source) n_mode = M_IDLE;
        end else if (i_in.end_of_source) begin
            // Flush the pending token.
            case (r_mode)
                M_NUMBER: begin
                    aq   = 1'b1;
                    aty  = TK_NUMBER;
                    anum = r_acc;
                end
                M_IDENT, M_VAR: begin
                    aq = 1'b1;
                    if (r_mode == M_VAR) aty = TK_VAR;
                    else if (r_km[0] && r_tc == TC_W'(4)) aty = TK_TRUE;
                    else if (r_km[1] && r_tc == TC_W'(5)) aty = TK_FALSE;
                    else aty = TK_IDENT;
                end
                M_VAR_START: begin
                    bnd.res[nr] = f_err(ER_EMPTYVAR, r_off, r_ln, r_col);
                    nr = nr + 2'd1;
                    n_mode = M_ERROR;
                end
                M_STRING, M_STRING_ESC: begin
                    bnd.res[nr] = f_err(ER_UNTERM, r_so, r_sl, r_sc);
                    nr = nr + 2'd1;
                    n_mode = M_ERROR;
                end
                M_HOLD: begin
                    aq = 1'b1;
                    case (r_held)
                        CH_DOT: aty = TK_DOT;
                        CH_EQ:  aty = TK_ASSIGN;
                        CH_GT:  aty = TK_GT;
                        CH_LT:  aty = TK_LT;
                        default: begin
                            aq = 1'b0;
                            bnd.res[nr] = f_err(ER_CHAR, r_so, r_sl, r_sc);
                            nr = nr + 2'd1;
                            n_mode = M_ERROR;
                        end
                    endcase
                end
                default: ;
            endcase
            if (aq) begin
                if (n_tok >= r_limit) begin
                    bnd.res[nr] = f_err(ER_MANY, r_so, r_sl, r_sc);
                    n_mode = M_ERROR;
                end else begin
                    bnd.res[nr] = f_rec(aty, r_so, r_sl, r_sc,
                                        (r_mode == M_IDENT || r_mode == M_VAR) ?
                                        r_tc[3:0] : 4'd0, anum);
                    n_tok = n_tok + 16'd1;
                end
                nr = nr + 2'd1;
            end
            // End of file record.
            if (n_mode != M_ERROR) begin
                if (n_tok >= r_limit) begin
                    bnd.res[nr] = f_err(ER_MANY, r_off, r_ln, r_col);
                end else begin
                    bnd.res[nr] = f_rec(TK_EOF, r_off, r_ln, r_col, 4'd0, 16'd0);
                end
                nr = nr + 2'd1;
            end
            n_mode = M_IDLE;
        end else begin
            // Mode-specific handling of the byte.
            case (r_mode)
                M_NUMBER: begin
                    if (b >= "0" && b <= "9") begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + {12'd0, b[3:0]};
                        n_col = n_col + 16'd1;
                    end else begin
                        n_mode = M_IDLE;
                        aq     = 1'b1;
                        adisp  = 1'b1;
                        aty    = TK_NUMBER;
                        anum   = r_acc;
                    end
                end
                M_IDENT, M_VAR: begin
                    if (f_is_word(b)) begin
                        if (r_tc < TEXT_KEEP) begin
                            n_km = f_kw(r_km, r_tc, f);
                            bnd.res[nr] = f_text(f);
                            nr = nr + 2'd1;
                            n_tc = r_tc + TC_W'(1);
                        end
                        n_col = n_col + 16'd1;
                    end else begin
                        n_mode = M_IDLE;
                        aq     = 1'b1;
                        adisp  = 1'b1;
                        if (r_mode == M_VAR) aty = TK_VAR;
                        else if (r_km[0] && r_tc == TC_W'(4)) aty = TK_TRUE;
                        else if (r_km[1] && r_tc == TC_W'(5)) aty = TK_FALSE;
                        else aty = TK_IDENT;
                    end
                end
                M_VAR_START: begin
                    if (f_is_word(b)) begin
                        n_so = r_off;
                        n_sl = r_ln;
                        n_sc = r_col;
                        n_km = 2'b00;
                        bnd.res[nr] = f_text(f);
                        nr = nr + 2'd1;
                        n_tc   = TC_W'(1);
                        n_mode = M_VAR;
                        n_col  = n_col + 16'd1;
                    end else begin
                        bnd.res[nr] = f_err(ER_EMPTYVAR, r_off, r_ln, r_col);
                        nr = nr + 2'd1;
                        n_mode = M_ERROR;
                    end
                end
                M_STRING, M_STRING_ESC: begin
                    if (r_mode == M_STRING && b == CH_QUOTE) begin
                        // Closing quote: the limit was checked at the opening quote.
                        n_mode = M_IDLE;
                        n_tok  = n_tok + 16'd1;
                        bnd.res[nr] = f_rec(TK_STRING, r_so, r_sl, r_sc, r_tc[3:0], 16'd0);
                        nr = nr + 2'd1;
                        n_col = n_col + 16'd1;
                    end else if (r_mode == M_STRING && b == CH_BSLASH) begin
                        n_mode = M_STRING_ESC;
                        n_col  = n_col + 16'd1;
                    end else begin
                        n_mode = M_STRING;
                        if (r_tc + TC_W'(1) >= TC_W'(TEXT_BYTES)) begin
                            bnd.res[nr] = f_err(ER_LONG, r_so, r_sl, r_sc);
                            nr = nr + 2'd1;
                            n_mode = M_ERROR;
                        end else begin
                            bnd.res[nr] = f_text(b);
                            nr = nr + 2'd1;
                            n_tc  = r_tc + TC_W'(1);
                            n_col = n_col + 16'd1;
                        end
                    end
                end
                M_HOLD: begin
                    if (r_held == CH_DOT && b == CH_DOT) begin pty = TK_RANGE; pok = 1'b1; end
                    else if (r_held == CH_EQ && b == CH_EQ) begin pty = TK_EQ; pok = 1'b1; end
                    else if (r_held == CH_BANG && b == CH_EQ) begin pty = TK_NEQ; pok = 1'b1; end
                    else if (r_held == CH_LT && b == CH_GT) begin pty = TK_NEQ; pok = 1'b1; end
                    else if (r_held == CH_GT && b == CH_EQ) begin pty = TK_GTE; pok = 1'b1; end
                    else if (r_held == CH_LT && b == CH_EQ) begin pty = TK_LTE; pok = 1'b1; end
                    n_mode = M_IDLE;
                    if (pok) begin
                        // Two-byte operator.
                        if (n_tok >= r_limit) begin
                            bnd.res[nr] = f_err(ER_MANY, r_so, r_sl, r_sc);
                            n_mode = M_ERROR;
                        end else begin
                            bnd.res[nr] = f_rec(pty, r_so, r_sl, r_sc, 4'd0, 16'd0);
                            n_tok = n_tok + 16'd1;
                            n_col = n_col + 16'd1;
                        end
                        nr = nr + 2'd1;
                    end else begin
                        aq    = 1'b1;
                        adisp = 1'b1;
                        case (r_held)
                            CH_DOT: aty = TK_DOT;
                            CH_EQ:  aty = TK_ASSIGN;
                            CH_GT:  aty = TK_GT;
                            CH_LT:  aty = TK_LT;
                            default: begin
                                aq = 1'b0;
                                adisp = 1'b0;
                                bnd.res[nr] = f_err(ER_CHAR, r_so, r_sl, r_sc);
                                nr = nr + 2'd1;
                                n_mode = M_ERROR;
                            end
                        endcase
                    end
                end
                M_AFTER_CR: begin
                    n_mode = M_IDLE;
                    disp   = (b != CH_LF);
                end
                default: disp = 1'b1;
            endcase

            // Record of the token that this byte closes.
            if (aq) begin
                if (n_tok >= r_limit) begin
                    bnd.res[nr] = f_err(ER_MANY, r_so, r_sl, r_sc);
                    n_mode = M_ERROR;
                end else begin
                    bnd.res[nr] = f_rec(aty, r_so, r_sl, r_sc,
                                        (r_mode == M_IDENT || r_mode == M_VAR) ?
                                        r_tc[3:0] : 4'd0, anum);
                    n_tok = n_tok + 16'd1;
                    disp  = adisp;
                end
                nr = nr + 2'd1;
            end

            // Start of a new token at this byte.
            if (disp) begin
                n_mode = M_IDLE;
                if (b == CH_SPACE || b == CH_TAB) begin
                    n_col = n_col + 16'd1;
                end else if (b == CH_CR || b == CH_LF) begin
                    if (n_tok >= r_limit) begin
                        bnd.res[nr] = f_err(ER_MANY, r_off, r_ln, n_col);
                        n_mode = M_ERROR;
                    end else begin
                        bnd.res[nr] = f_rec(TK_NEWLINE, r_off, r_ln, n_col, 4'd0, 16'd0);
                        n_tok  = n_tok + 16'd1;
                        n_ln   = r_ln + 16'd1;
                        n_col  = 16'd1;
                        n_mode = (b == CH_CR) ? M_AFTER_CR : M_IDLE;
                    end
                    nr = nr + 2'd1;
                end else if (b == CH_QUOTE) begin
                    if (n_tok >= r_limit) begin
                        bnd.res[nr] = f_err(ER_MANY, r_off, r_ln, n_col);
                        nr = nr + 2'd1;
                        n_mode = M_ERROR;
                    end else begin
                        n_so   = r_off;
                        n_sl   = r_ln;
                        n_sc   = n_col;
                        n_tc   = '0;
                        n_mode = M_STRING;
                        n_col  = n_col + 16'd1;
                    end
                end else if (b >= "0" && b <= "9") begin
                    n_so   = r_off;
                    n_sl   = r_ln;
                    n_sc   = n_col;
                    n_acc  = {12'd0, b[3:0]};
                    n_mode = M_NUMBER;
                    n_col  = n_col + 16'd1;
                end else if (b == CH_DOLLAR) begin
                    n_mode = M_VAR_START;
                    n_col  = n_col + 16'd1;
                end else if (f_is_word(b)) begin
                    n_so   = r_off;
                    n_sl   = r_ln;
                    n_sc   = n_col;
                    n_km   = f_kw(2'b11, TC_W'(0), f);
                    bnd.res[nr] = f_text(f);
                    nr = nr + 2'd1;
                    n_tc   = TC_W'(1);
                    n_mode = M_IDENT;
                    n_col  = n_col + 16'd1;
                end else if (b == CH_DOT || b == CH_EQ || b == CH_BANG ||
                             b == CH_LT || b == CH_GT) begin
                    n_so   = r_off;
                    n_sl   = r_ln;
                    n_sc   = n_col;
                    n_held = b;
                    n_mode = M_HOLD;
                    n_col  = n_col + 16'd1;
                end else if (!sg[5]) begin
                    bnd.res[nr] = f_err(ER_CHAR, r_off, r_ln, n_col);
                    nr = nr + 2'd1;
                    n_mode = M_ERROR;
                end else begin
                    if (n_tok >= r_limit) begin
                        bnd.res[nr] = f_err(ER_MANY, r_off, r_ln, n_col);
                        n_mode = M_ERROR;
                    end else begin
                        bnd.res[nr] = f_rec(sg[4:0], r_off, r_ln, n_col, 4'd0, 16'd0);
                        n_tok = n_tok + 16'd1;
                        n_col = n_col + 16'd1;
                    end
                    nr = nr + 2'd1;
                end
            end
            n_off = r_off + 16'd1;
        end
        bnd.cnt = nr;
    end

    // Scan state; the end marker returns it to the reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_off   <= 16'd0;
            r_ln    <= 16'd1;
            r_col   <= 16'd1;
            r_so    <= 16'd0;
            r_sl    <= 16'd1;
            r_sc    <= 16'd1;
            r_acc   <= 16'd0;
            r_tc    <= '0;
            r_tok   <= 16'd0;
            r_km    <= 2'b11;
            r_held  <= 8'd0;
            r_limit <= LIMIT_RESET;
        end else begin
            if (i_cfg.valid) r_limit <= i_cfg.token_limit;
            if (accept) begin
                if (i_in.end_of_source) begin
                    r_mode <= M_IDLE;
                    r_off  <= 16'd0;
                    r_ln   <= 16'd1;
                    r_col  <= 16'd1;
                    r_so   <= 16'd0;
                    r_sl   <= 16'd1;
                    r_sc   <= 16'd1;
                    r_acc  <= 16'd0;
                    r_tc   <= '0;
                    r_tok  <= 16'd0;
                    r_km   <= 2'b11;
                    r_held <= 8'd0;
                end else begin
                    r_mode <= n_mode;
                    r_off  <= n_off;
                    r_ln   <= n_ln;
                    r_col  <= n_col;
                    r_so   <= n_so;
                    r_sl   <= n_sl;
                    r_sc   <= n_sc;
                    r_acc  <= n_acc;
                    r_tc   <= n_tc;
                    r_tok  <= n_tok;
                    r_km   <= n_km;
                    r_held <= n_held;
                end
            end
        end
    end

endmodule

// ----- sv/sst_queue.sv -----
// ----------------------------------------------------------------------------
// Result bundle queue
// Short first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module sst_queue
    import sst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output t_qstat  o_qstat,
    output t_bundle o_head
);

    t_bundle           r_mem [QDEPTH];
    logic [QA_W-1:0]   r_wp, r_rp;
    logic [QA_W:0]     r_cnt;

    assign o_qstat.full  = (r_cnt == (QA_W+1)'(QDEPTH));
    assign o_qstat.valid = (r_cnt != '0);
    assign o_head        = r_mem[r_rp];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QA_W'(1);
            if (i_pop) r_rp <= r_rp + QA_W'(1);
            if (i_push && !i_pop) r_cnt <= r_cnt + (QA_W+1)'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - (QA_W+1)'(1);
        end
    end

endmodule

// ----- sv/sst_back.sv -----
// ----------------------------------------------------------------------------
// Tokenizer back end
// Takes bundles apart into single results and drives the output register.
// ----------------------------------------------------------------------------
module sst_back
    import sst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_qstat   i_qstat,
    input  t_bundle  i_head,
    output logic     o_pop,
    sst_out_if.source o_out
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_result    r_data;
    logic       r_last;
    logic       load;
    logic       at_end;

    assign load   = i_qstat.valid && (!r_valid || o_out.ready);
    assign at_end = (r_idx == i_head.cnt - 2'd1);
    assign o_pop  = load && at_end;

    // Output register and position within the head bundle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_head.res[r_idx];
            r_last <= at_end;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.result_kind   = r_data.kind;
    assign o_out.token_type    = r_data.ttype;
    assign o_out.text_byte     = r_data.text;
    assign o_out.offset        = r_data.offset;
    assign o_out.line_number   = r_data.line;
    assign o_out.column_number = r_data.column;
    assign o_out.text_length   = r_data.tlen;
    assign o_out.number_value  = r_data.num;
    assign o_out.error_code    = r_data.ecode;
    assign o_out.last_in_run   = r_last;

endmodule

// ----- sv/shell_script_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// Shell script tokenizer
// Streaming lexer: source bytes in, text bytes, token and error records out.
// ----------------------------------------------------------------------------
// Usage:
//   i_in takes one source byte per transaction, or the end marker, which
//   flushes any pending token, emits EOF unless an error stops the scan
//   and clears the scan state. o_out gives one result per transaction;
//   last_in_run marks the final result caused by an input transaction. i_cfg
//   writes the token limit and should only be used while the block is idle.
// Flow:
//   A byte is scanned in the cycle it is accepted; its results are written
//   to the bundle queue and then loaded into the output register. The front
//   accepts a byte every cycle while the bundle queue has room. The output
//   register delivers one result per cycle while results are queued and o_out is ready.
// Reset:
//   Synchronous, active low. The scanner returns to line 1, column 1, the
//   token limit to 256, and the queue and output register empty.
// Stalls:
//   When o_out is stalled, the four-entry queue fills and i_in.ready drops.
// ----------------------------------------------------------------------------
module shell_script_tokenizer_unit
    import sst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sst_in_if.sink    i_in,
    sst_cfg_if.sink   i_cfg,
    sst_out_if.source o_out
);

    t_qstat  qstat;
    t_bundle push_bundle;
    t_bundle head;
    logic    push;
    logic    pop;

    // Scanner.
    sst_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    // Decoupling queue.
    sst_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_qstat  (qstat),
        .o_head   (head)
    );

    // Result serialiser.
    sst_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ----- sv/sst_checker.sv -----
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Concurrent assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sst_checker
    import sst_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [4:0]  i_type,
    input logic [15:0] i_offset,
    input logic [15:0] i_line
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    // Nothing is offered in the cycle after reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result offered after reset");

    // Only the three defined kinds are produced.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_kind == RK_TEXT || i_kind == RK_RECORD || i_kind == RK_ERROR))
        else $error("undefined result kind");

    // Text results carry no position and no token type.
    a_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == RK_TEXT |-> i_offset == 16'd0 && i_line == 16'd0 &&
        i_type == 5'd0)
        else $error("text result with position fields");

    // Records carry one of the defined token types.
    a_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == RK_RECORD |-> i_type <= TK_EOF)
        else $error("token type out of range");

endmodule

bind shell_script_tokenizer_unit sst_checker u_sst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_kind   (o_out.result_kind),
    .i_type   (o_out.token_type),
    .i_offset (o_out.offset),
    .i_line   (o_out.line_number)
);

// ----- dv/sst_tb_if.sv -----
// ----------------------------------------------------------------------------
// Testbench channel notes
// The block's own channel interfaces are used directly; this file holds the
// testbench type that the checker uses for its expected results.
// ----------------------------------------------------------------------------
package sst_tb_pkg;
    import sst_pkg::*;

    // One expected result with its run flag.
    typedef struct packed {
        t_result res;
        logic    last;
    } t_expect;
endpackage

// ----- dv/sst_checker.sv -----
// ----------------------------------------------------------------------------
// Tokenizer checker
// Watches the input, configuration and result channels, predicts the results
// of every accepted source transaction and compares them in order.
// ----------------------------------------------------------------------------
module sst_scoreboard
    import sst_pkg::*;
    import sst_tb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    sst_in_if      i_in,
    sst_cfg_if     i_cfg,
    sst_out_if     i_out,
    output int     o_errors,
    output int     o_pending
);

    // Predictor state.
    logic [15:0] limit_q;
    t_mode       mode;
    logic [15:0] pos_off, pos_line, pos_col;
    logic [15:0] st_off, st_line, st_col;
    logic [15:0] num_acc;
    int          tcount;
    logic [15:0] emitted;
    logic [1:0]  kwm;
    logic [7:0]  held;
    t_result     run_q[$];
    t_expect     expected_results[$];

    assign o_pending = expected_results.size();

    function automatic logic word_char(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h30 && b <= 8'h39) || b == 8'h5F;
    endfunction

    function automatic t_result mk(logic [1:0] k, logic [4:0] ty, logic [7:0] tx,
                                   logic [15:0] o, logic [15:0] l, logic [15:0] c,
                                   logic [3:0] len, logic [15:0] n, logic [2:0] e);
        t_result r;
        r = '0;
        r.kind = k; r.ttype = ty; r.text = tx; r.offset = o; r.line = l;
        r.column = c; r.tlen = len; r.num = n; r.ecode = e;
        return r;
    endfunction

    task automatic clear_scan();
        mode = M_IDLE; pos_off = 16'd0; pos_line = 16'd1; pos_col = 16'd1;
        st_off = 16'd0; st_line = 16'd1; st_col = 16'd1; num_acc = 16'd0; tcount = 0;
        emitted = 16'd0; kwm = 2'b11; held = 8'd0;
    endtask

    function automatic void raise_error(logic [2:0] code, logic [15:0] o, logic [15:0] l,
                                        logic [15:0] c);
        mode = M_ERROR;
        run_q.push_back(mk(RK_ERROR, '0, '0, o, l, c, '0, '0, code));
    endfunction

    // Emits a token record unless the limit is reached, then reports error.
    function automatic logic emit_token(logic [4:0] ty, logic [15:0] o, logic [15:0] l,
                                        logic [15:0] c, int len, logic [15:0] n);
        if (emitted >= limit_q) begin
            raise_error(ER_MANY, o, l, c);
            return 1'b0;
        end
        emitted = emitted + 16'd1;
        run_q.push_back(mk(RK_RECORD, ty, '0, o, l, c, len[3:0], n, '0));
        return 1'b1;
    endfunction

    task automatic mark();
        st_off = pos_off; st_line = pos_line; st_col = pos_col;
    endtask

    task automatic add_word(logic [7:0] b);
        logic [7:0] f;
        f = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
        if (tcount >= TEXT_BYTES - 1) return;
        if (tcount >= 4 || f != 8'("TRUE"  >> (8 * (3 - tcount)))) kwm[0] = 1'b0;
        if (tcount >= 5 || f != 8'("FALSE" >> (8 * (4 - tcount)))) kwm[1] = 1'b0;
        run_q.push_back(mk(RK_TEXT, '0, f, '0, '0, '0, '0, '0, '0));
        tcount++;
    endtask

    function automatic logic close_word();
        logic [4:0] ty;
        ty = TK_IDENT;
        if (mode == M_VAR) ty = TK_VAR;
        else if (kwm[0] && tcount == 4) ty = TK_TRUE;
        else if (kwm[1] && tcount == 5) ty = TK_FALSE;
        mode = M_IDLE;
        return emit_token(ty, st_off, st_line, st_col, tcount, '0);
    endfunction

    function automatic logic close_single();
        logic [4:0] ty;
        mode = M_IDLE;
        case (held)
            CH_DOT: ty = TK_DOT;
            CH_EQ:  ty = TK_ASSIGN;
            CH_GT:  ty = TK_GT;
            CH_LT:  ty = TK_LT;
            default: begin
                raise_error(ER_CHAR, st_off, st_line, st_col);
                return 1'b0;
            end
        endcase
        return emit_token(ty, st_off, st_line, st_col, 0, '0);
    endfunction

    task automatic str_byte(logic [7:0] b);
        if (tcount + 1 >= TEXT_BYTES) begin
            raise_error(ER_LONG, st_off, st_line, st_col);
            return;
        end
        run_q.push_back(mk(RK_TEXT, '0, b, '0, '0, '0, '0, '0, '0));
        tcount++;
        pos_col++;
    endtask

    // Handles a byte seen from the idle state.
    task automatic start_token(logic [7:0] b);
        logic [4:0] ty;
        logic       hit;
        mode = M_IDLE;
        hit = 1'b1;
        ty = TK_EOF;
        if (b == CH_SPACE || b == CH_TAB) begin
            pos_col++;
        end else if (b == CH_CR || b == CH_LF) begin
            if (emit_token(TK_NEWLINE, pos_off, pos_line, pos_col, 0, '0)) begin
                pos_line++; pos_col = 16'd1;
                mode = (b == CH_CR) ? M_AFTER_CR : M_IDLE;
            end
        end else if (b == CH_QUOTE) begin
            if (emitted >= limit_q) raise_error(ER_MANY, pos_off, pos_line, pos_col);
            else begin
                mark(); tcount = 0; mode = M_STRING; pos_col++;
            end
        end else if (b >= 8'h30 && b <= 8'h39) begin
            mark(); num_acc = 16'(b - 8'h30); mode = M_NUMBER; pos_col++;
        end else if (b == CH_DOLLAR) begin
            mode = M_VAR_START; pos_col++;
        end else if (word_char(b)) begin
            mark(); tcount = 0; kwm = 2'b11; add_word(b); mode = M_IDENT; pos_col++;
        end else if (b == CH_DOT || b == CH_EQ || b == CH_BANG || b == CH_LT
                     || b == CH_GT) begin
            mark(); held = b; mode = M_HOLD; pos_col++;
        end else begin
            case (b)
                "@": ty = TK_AT;      "|": ty = TK_PIPE;
                "?": ty = TK_QUEST;   "%": ty = TK_PERCENT;
                "[": ty = TK_LBRACK;  "]": ty = TK_RBRACK;
                "(": ty = TK_LPAREN;  ")": ty = TK_RPAREN;
                ",": ty = TK_COMMA;   ";": ty = TK_SEMI;
                default: hit = 1'b0;
            endcase
            if (!hit) raise_error(ER_CHAR, pos_off, pos_line, pos_col);
            else if (emit_token(ty, pos_off, pos_line, pos_col, 0, '0)) pos_col++;
        end
    endtask

    // Works out the results of one accepted source transaction.
    task automatic scan_item(logic [7:0] b, logic eos);
        logic [4:0] ty;
        t_expect    e;
        run_q.delete();
        if (mode == M_ERROR) begin
            if (eos) clear_scan();
        end else if (eos) begin
            case (mode)
                M_NUMBER: begin
                    mode = M_IDLE;
                    void'(emit_token(TK_NUMBER, st_off, st_line, st_col, 0, num_acc));
                end
                M_IDENT, M_VAR: void'(close_word());
                M_VAR_START: raise_error(ER_EMPTYVAR, pos_off, pos_line, pos_col);
                M_STRING, M_STRING_ESC: raise_error(ER_UNTERM, st_off, st_line, st_col);
                M_HOLD: void'(close_single());
                default: ;
            endcase
            if (mode != M_ERROR)
                void'(emit_token(TK_EOF, pos_off, pos_line, pos_col, 0, '0));
            clear_scan();
        end else begin
            case (mode)
                M_NUMBER: begin
                    if (b >= 8'h30 && b <= 8'h39) begin
                        num_acc = num_acc * 16'd10 + 16'(b - 8'h30);
                        pos_col++;
                    end else begin
                        mode = M_IDLE;
                        if (emit_token(TK_NUMBER, st_off, st_line, st_col, 0, num_acc))
                            start_token(b);
                    end
                end
                M_IDENT, M_VAR: begin
                    if (word_char(b)) begin
                        add_word(b); pos_col++;
                    end else if (close_word()) start_token(b);
                end
                M_VAR_START: begin
                    if (word_char(b)) begin
                        mark(); tcount = 0; kwm = 2'b00; add_word(b);
                        mode = M_VAR; pos_col++;
                    end else raise_error(ER_EMPTYVAR, pos_off, pos_line, pos_col);
                end
                M_STRING: begin
                    if (b == CH_QUOTE) begin
                        mode = M_IDLE;
                        emitted = emitted + 16'd1;
                        run_q.push_back(mk(RK_RECORD, TK_STRING, '0, st_off, st_line,
                                           st_col, tcount[3:0], '0, '0));
                        pos_col++;
                    end else if (b == CH_BSLASH) begin
                        mode = M_STRING_ESC; pos_col++;
                    end else str_byte(b);
                end
                M_STRING_ESC: begin
                    mode = M_STRING; str_byte(b);
                end
                M_HOLD: begin
                    ty = 5'h1F;
                    if (held == CH_DOT && b == CH_DOT) ty = TK_RANGE;
                    else if (held == CH_EQ && b == CH_EQ) ty = TK_EQ;
                    else if (held == CH_BANG && b == CH_EQ) ty = TK_NEQ;
                    else if (held == CH_LT && b == CH_GT) ty = TK_NEQ;
                    else if (held == CH_GT && b == CH_EQ) ty = TK_GTE;
                    else if (held == CH_LT && b == CH_EQ) ty = TK_LTE;
                    if (ty != 5'h1F) begin
                        mode = M_IDLE;
                        if (emit_token(ty, st_off, st_line, st_col, 0, '0)) pos_col++;
                    end else if (close_single()) start_token(b);
                end
                M_AFTER_CR: begin
                    mode = M_IDLE;
                    if (b != CH_LF) start_token(b);
                end
                default: start_token(b);
            endcase
            pos_off++;
        end
        foreach (run_q[i]) begin
            e.res  = run_q[i];
            e.last = (i == run_q.size() - 1);
            expected_results.push_back(e);
        end
    endtask

    // Predict on accepted transactions and compare each accepted result.
    always @(posedge i_clk) begin
        t_expect e;
        t_result got;
        if (!i_rst_n) begin
            limit_q = LIMIT_RESET;
            clear_scan();
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) limit_q = i_cfg.token_limit;
            if (i_out.valid && i_out.ready) begin
                got = mk(i_out.result_kind, i_out.token_type, i_out.text_byte,
                         i_out.offset, i_out.line_number, i_out.column_number,
                         i_out.text_length, i_out.number_value, i_out.error_code);
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h last %b", $time, got,
                             i_out.last_in_run);
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (e.res !== got || e.last !== i_out.last_in_run) begin
                        $display("%0t: mismatch expected %h last %b, actual %h last %b",
                                 $time, e.res, e.last, got, i_out.last_in_run);
                        o_errors++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) scan_item(i_in.char_byte, i_in.end_of_source);
        end
    end

endmodule

// ----- dv/shell_script_tokenizer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Tokenizer testbench
// Drives source bytes and token limit writes into the tokenizer, with random
// gaps and output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module shell_script_tokenizer_unit_tb;
    import sst_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    bit   calm;
    int   hold_cycles;
    int   sent;

    sst_in_if  src_if();
    sst_cfg_if cfg_if();
    sst_out_if res_if();

    shell_script_tokenizer_unit u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (src_if),
        .i_cfg  (cfg_if),
        .o_out  (res_if)
    );

    sst_scoreboard u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (src_if),
        .i_cfg    (cfg_if),
        .i_out    (res_if),
        .o_errors (mismatches),
        .o_pending(pending)
    );

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    // Result side: random stall bursts, or a long hold when asked.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_cycles--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge i_clk);
            end else res_if.ready <= 1'b1;
        end
    end

    // Sends one source transaction, at times with a random gap burst ahead of it.
    // Valid stays high on return so that transactions can follow back to back.
    task automatic send(logic [7:0] b, logic eos);
        if (!calm && $urandom_range(0, 4) == 0) begin
            src_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        src_if.valid         <= 1'b1;
        src_if.char_byte     <= b;
        src_if.end_of_source <= eos;
        @(posedge i_clk);
        while (!src_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send(s[i], 1'b0);
    endtask

    // Stops offering input and waits until every expected result has left.
    task automatic drain();
        src_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic set_limit(logic [15:0] v);
        drain();
        cfg_if.valid       <= 1'b1;
        cfg_if.token_limit <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Picks a byte that is mostly well-formed shell text.
    function automatic logic [7:0] pick_byte();
        int    r;
        string pool;
        pool = "abcXYZ_09 \t\"\\$.=!<>@|?%[](),;\r\n";
        r = $urandom_range(0, 19);
        if (r < 16) return pool[$urandom_range(0, pool.len() - 1)];
        if (r < 18) return 8'($urandom_range(0, 255));
        return "e";
    endfunction

    initial begin
        int       k;
        int       n;
        calm = 0; hold_cycles = 0; sent = 0;
        i_rst_n = 1'b0;
        src_if.valid = 1'b0; src_if.char_byte = 8'h00; src_if.end_of_source = 1'b0;
        cfg_if.valid = 1'b0; cfg_if.token_limit = 16'd0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: keywords, operators, numbers, strings and the error cases other than too many tokens.
        send_text("true False tRuEx $v_1 65536 99999 .. == != <> >= <= = > < .");
        send_text("@|?%[](),;\r\n\rx\"a\\\"b\r\"");
        send(8'h00, 1'b1);
        send(8'hFF, 1'b0); send(8'h00, 1'b1);
        send_text("a!b"); send(8'h00, 1'b1);
        send_text("$ "); send(8'h00, 1'b1);
        send_text("$"); send(8'h00, 1'b1);
        send_text("\"abcdefghijklmnopq\""); send(8'h00, 1'b1);
        send_text("\"ab\\"); send(8'h00, 1'b1);
        send_text("abcdefghijklmnopqrs !"); send(8'h00, 1'b1);

        // Limits: extremes and small values so the too-many case is reached.
        set_limit(16'd0);
        send_text("x"); send(8'h00, 1'b1);
        send(8'h00, 1'b1);
        set_limit(16'd2);
        send_text("a \"s\" b"); send(8'h00, 1'b1);
        set_limit(16'd1);
        send_text("\"q\""); send(8'h00, 1'b1);

        // Long output hold so the queue fills and the input stalls.
        set_limit(16'hFFFF);
        hold_cycles = 60;
        send_text("a b c d e f g h i j");

        // Random sources with varied limits; no idling in the last part.
        for (k = 0; k < 6; k++) begin
            if (k == 2) set_limit(16'd5);
            if (k == 4) begin
                set_limit(16'd256);
                calm = 1;
            end
            n = $urandom_range(4, 10);
            repeat (n) send(pick_byte(), 1'b0);
            send(pick_byte(), 1'b1);
        end

        drain();
        if (mismatches == 0 && pending == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    // Hard stop for a hung run.
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule
